// ===== rtl/zwpcd_pkg.sv =====
// ----------------------------------------------------------------------------
// zwpcd_pkg: shared types and constants for the zero-width pair decoder
// Byte codes of the zero-width characters, prefix progress encoding and
// the decode result structure handed to the output register.
// ----------------------------------------------------------------------------
package zwpcd_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CmdW  = 3;
    localparam int unsigned SymW  = 2;

    localparam logic [ByteW-1:0] LEAD_BYTE  = 8'hE2;
    localparam logic [ByteW-1:0] MID_BYTE   = 8'h80;
    localparam logic [ByteW-1:0] SYM1_BYTE  = 8'h8B;
    localparam logic [ByteW-1:0] SYM2_BYTE  = 8'h8C;
    localparam logic [ByteW-1:0] SYM3_BYTE  = 8'h8D;
    localparam logic [ByteW-1:0] SPACE_BYTE = 8'h20;

    localparam logic [SymW-1:0] SYM_NONE = 2'd0;
    localparam logic [SymW-1:0] SYM_ONE  = 2'd1;
    localparam logic [SymW-1:0] SYM_TWO  = 2'd2;
    localparam logic [SymW-1:0] SYM_THREE = 2'd3;

    // Pair three-three yields this code and is dropped
    localparam logic [3:0] DROPPED_CODE = 4'd8;

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_LEAD = 2'd1,
        PFX_MID  = 2'd2
    } t_prefix;

    typedef struct packed {
        logic            valid;
        logic [CmdW-1:0] command;
    } t_dec_result;

    function automatic logic [SymW-1:0] symbol_of(input logic [ByteW-1:0] b);
        logic [SymW-1:0] s;
        s = SYM_NONE;
        if (b == SYM1_BYTE) s = SYM_ONE;
        else if (b == SYM2_BYTE) s = SYM_TWO;
        else if (b == SYM3_BYTE) s = SYM_THREE;
        return s;
    endfunction

    // code = (first - 1) * 3 + (second - 1), both symbols nonzero
    function automatic logic [3:0] pair_code(input logic [SymW-1:0] first,
                                             input logic [SymW-1:0] second);
        logic [3:0] f;
        logic [3:0] s;
        f = {2'b00, first - SYM_ONE};
        s = {2'b00, second - SYM_ONE};
        return (f << 1) + f + s;
    endfunction

endpackage

// ===== rtl/zwpcd_if.sv =====
// ----------------------------------------------------------------------------
// zwpcd_if: valid/ready channels of the zero-width pair decoder
// Byte channel into the decoder and command channel out of it.
// ----------------------------------------------------------------------------
interface zwpcd_in_if;
    import zwpcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] data_byte;
    logic             end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface zwpcd_out_if;
    import zwpcd_pkg::*;

    logic            valid;
    logic            ready;
    logic [CmdW-1:0] command;

    modport source (output valid, output command, input ready);
    modport sink   (input valid, input command, output ready);
endinterface

// ===== rtl/zwpcd_decode.sv =====
// ----------------------------------------------------------------------------
// zwpcd_decode: prefix tracking and symbol pairing
// Holds prefix progress and the pending first symbol; forms one command
// from two symbols. State advances only when a byte leaves the input stage.
// ----------------------------------------------------------------------------
module zwpcd_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic [zwpcd_pkg::ByteW-1:0]       i_byte,
    input  logic                              i_eos,
    output zwpcd_pkg::t_dec_result            o_res,
    output logic                              o_idle
);
    import zwpcd_pkg::*;

    t_prefix         r_prefix, n_prefix;
    logic [SymW-1:0] r_pending, n_pending;
    logic [SymW-1:0] w_sym;
    logic            w_break;
    logic [3:0]      w_code;

    // Next prefix progress and symbol detection
    always_comb begin
        n_prefix = PFX_NONE;
        w_sym    = SYM_NONE;
        w_break  = 1'b0;
        case (r_prefix)
            PFX_LEAD: begin
                if (i_byte == MID_BYTE) begin
                    n_prefix = PFX_MID;
                end else begin
                    w_break  = 1'b1;
                    n_prefix = (i_byte == LEAD_BYTE) ? PFX_LEAD : PFX_NONE;
                end
            end
            PFX_MID: begin
                w_sym = symbol_of(i_byte);
                if (w_sym == SYM_NONE) begin
                    w_break  = 1'b1;
                    n_prefix = (i_byte == LEAD_BYTE) ? PFX_LEAD : PFX_NONE;
                end
            end
            default: begin
                if (i_byte == LEAD_BYTE) begin
                    n_prefix = PFX_LEAD;
                end else if (i_byte != SPACE_BYTE) begin
                    w_break = 1'b1;
                end
            end
        endcase
    end

    // Pairing and command result
    always_comb begin
        w_code        = pair_code(r_pending, w_sym);
        n_pending     = w_break ? SYM_NONE : r_pending;
        o_res.valid   = 1'b0;
        o_res.command = w_code[CmdW-1:0];
        if (w_sym != SYM_NONE) begin
            if (r_pending == SYM_NONE) begin
                n_pending = w_sym;
            end else begin
                n_pending   = SYM_NONE;
                o_res.valid = (w_code != DROPPED_CODE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix  <= PFX_NONE;
            r_pending <= SYM_NONE;
        end else if (i_advance) begin
            // Drop leftover prefix and lone symbol at end of stream
            r_prefix  <= i_eos ? PFX_NONE : n_prefix;
            r_pending <= i_eos ? SYM_NONE : n_pending;
        end
    end

    assign o_idle = (r_prefix == PFX_NONE) && (r_pending == SYM_NONE);

endmodule

// ===== rtl/zwpcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// zwpcd_out_reg: command result register
// Holds one command until the downstream transfer completes.
// ----------------------------------------------------------------------------
module zwpcd_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  zwpcd_pkg::t_dec_result        i_res,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [zwpcd_pkg::CmdW-1:0]    o_command,
    output logic                          o_can_take
);
    import zwpcd_pkg::*;

    logic            r_valid;
    logic [CmdW-1:0] r_command;

    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_res.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_command <= i_res.command;
        end
    end

    assign o_valid   = r_valid;
    assign o_command = r_command;

endmodule

// ===== rtl/zero_width_pair_command_decoder.sv =====
// ----------------------------------------------------------------------------
// zero_width_pair_command_decoder: zero-width character pair to command
// Path: a byte that completes a command passes the input register, then
//   decode and the result register, before it shows on o_out.
// Throughput: one byte per cycle while the result register can take each
//   command, set by the single decode step between the input register
//   and the result register; a command byte stalls while that is full.
// Reset: synchronous, active low; clears prefix progress, the pending
//   symbol and both valid flags.
// ----------------------------------------------------------------------------
module zero_width_pair_command_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    zwpcd_in_if.sink     i_in,
    zwpcd_out_if.source  o_out
);
    import zwpcd_pkg::*;

    // Input register: one raw byte with its end-of-stream mark
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_eos;

    t_dec_result w_res;
    logic        w_idle;
    logic        w_out_can_take;
    logic        w_advance;

    // A byte leaves the input register when it yields no command, or when
    // the result register can take the command it yields.
    assign w_advance = r_in_valid && (!w_res.valid || w_out_can_take);

    // Accept a new byte whenever the input register empties this cycle
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eos  <= i_in.end_of_stream;
        end
    end

    // Decode: prefix tracking, symbol pairing, end-of-stream clear
    zwpcd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_eos     (r_in_eos),
        .o_res     (w_res),
        .o_idle    (w_idle)
    );

    // Result register: hold the command until the output transfer
    zwpcd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance),
        .i_res      (w_res),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_command  (o_out.command),
        .o_can_take (w_out_can_take)
    );

`ifndef SYNTHESIS
    // A stalled byte stays in the input register unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)
                                        && $stable(r_in_eos)))
        else $error("input register lost a stalled byte");

    // A command produced by decode appears at the output next cycle
    a_cmd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res.valid) |=> (o_out.valid
                                        && o_out.command == $past(w_res.command)))
        else $error("decoded command did not reach the output");

    // The last byte of a stream leaves the decoder with clear state
    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_eos) |=> w_idle)
        else $error("decoder state not cleared after end of stream");
`endif

endmodule
